[rtl/gfsr_r250_generator_defines.svh]
// assertion macros for the r250 gfsr generator
// used by modules that include this header; needs clk and rst_n in scope
`ifndef GFSR_R250_GENERATOR_DEFINES_SVH
`define GFSR_R250_GENERATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GFSR_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define GFSR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/gfsr_pkg.sv]
// shared types, constants and helper functions for the r250 gfsr generator
// no dependencies
package gfsr_pkg;

    localparam int TABLE_DEPTH  = 250;
    localparam int TAP_DISTANCE = 103;
    localparam int FIX_FIRST    = 3;
    localparam int FIX_STRIDE   = 11;
    localparam int WORD_W       = 32;
    localparam int POS_W        = $clog2(TABLE_DEPTH);

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [POS_W-1:0]  pos_t;

    // request kind carried on tuser
    typedef enum logic {
        FUNC_SEED = 1'b0,
        FUNC_DRAW = 1'b1
    } func_t;

    // table write port
    typedef struct packed {
        logic  en;
        pos_t  addr;
        word_t data;
    } tbl_wr_t;

    // table read port, two addresses per cycle
    typedef struct packed {
        logic en;
        pos_t addr_a;
        pos_t addr_b;
    } tbl_rd_t;

    // advance a table position with wrap
    function automatic pos_t pos_wrap_next(pos_t p);
        return (p == POS_W'(TABLE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // position of the tap partner, TAP_DISTANCE ahead with wrap
    function automatic pos_t pos_tap(pos_t p);
        return (p >= POS_W'(TABLE_DEPTH - TAP_DISTANCE)) ?
            p - POS_W'(TABLE_DEPTH - TAP_DISTANCE) : p + POS_W'(TAP_DISTANCE);
    endfunction

    // force bit k set and lower bits clear at the k-th fix position
    function automatic word_t independence_fix(pos_t pos, word_t w);
        word_t       r;
        word_t       bit_k;
        int unsigned spot;
        r    = w;
        spot = FIX_FIRST;
        for (int k = 0; k < WORD_W; k++)
        begin
            bit_k = word_t'(1) << k;
            if (pos == POS_W'(spot))
            begin
                r = (r & ~(bit_k - word_t'(1))) | bit_k;
            end
            spot = spot + FIX_STRIDE;
            if (spot >= TABLE_DEPTH)
            begin
                spot = spot - TABLE_DEPTH;
            end
        end
        return r;
    endfunction

endpackage

[rtl/gfsr_table.sv]
// word table: one write and two registered reads per cycle, write bypass
// and per-entry valid bits so unwritten entries read as zero; uses gfsr_pkg
module gfsr_table
    import gfsr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  tbl_rd_t rd,
    input  tbl_wr_t wr,
    output word_t   rd_data_a,
    output word_t   rd_data_b
);

    word_t                  mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    word_t                  mem_a_reg;
    word_t                  mem_b_reg;
    logic                   vld_a_reg;
    logic                   vld_b_reg;
    logic                   fwd_a_reg;
    logic                   fwd_b_reg;
    word_t                  fwd_data_reg;

    // storage write
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // registered storage reads
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            mem_a_reg <= mem[rd.addr_a];
            mem_b_reg <= mem[rd.addr_b];
        end
    end

    // entry valid bits, cleared together at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    // read flags: entry valid, or bypass from the write in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            fwd_a_reg <= 1'b0;
            fwd_b_reg <= 1'b0;
        end
        else if (rd.en)
        begin
            vld_a_reg <= valid_reg[rd.addr_a];
            vld_b_reg <= valid_reg[rd.addr_b];
            fwd_a_reg <= wr.en && (wr.addr == rd.addr_a);
            fwd_b_reg <= wr.en && (wr.addr == rd.addr_b);
        end
    end

    // bypass data
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            fwd_data_reg <= wr.data;
        end
    end

    // read data select
    assign rd_data_a = fwd_a_reg ? fwd_data_reg : (vld_a_reg ? mem_a_reg : '0);
    assign rd_data_b = fwd_b_reg ? fwd_data_reg : (vld_b_reg ? mem_b_reg : '0);

endmodule

[rtl/gfsr_r250_generator.sv]
// Usage of the r250 gfsr generator
// Input channel s_*: one request per accepted item. s_tuser selects the kind:
//   seed (0) writes s_tdata at the next load position, with the bit-column
//   fix applied at the fix positions, and rewinds the draw position to 0;
//   draw (1) returns one 32-bit word on m_* and ignores s_tdata.
// Output channel m_*: one item per draw request, none per seed request.
// Path: a draw's table reads are registered in the read stage when it is accepted,
//   and the result register takes the feedback word when the read stage advances.
// Throughput: one request per cycle, seeds and draws in any mix, while no draw
//   is held by a stalled result; the table can read two words and write one in
//   a cycle, with a same-cycle write bypass.
// Reset: positions go to 0 and the 250 table entries read as zero at once
//   through per-entry valid bits; no clearing pass, ready right after reset.
// Stall: the result register holds while m_tready is low; one further draw
//   waits in the read stage and s_tready drops only then. Seeds still pass
//   while a result waits.
// uses gfsr_pkg, gfsr_table and gfsr_r250_generator_defines.svh
`include "gfsr_r250_generator_defines.svh"

module gfsr_r250_generator
    import gfsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] seed_word
    input  logic        s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] value
);

    pos_t    draw_pos_reg;
    pos_t    load_pos_reg;
    logic    s1_valid_reg;
    logic    s1_draw_reg;
    pos_t    s1_addr_reg;
    word_t   s1_seed_reg;
    logic    out_valid_reg;
    word_t   out_data_reg;

    logic    s_accept;
    logic    in_draw;
    logic    s1_adv;
    word_t   tap_a;
    word_t   tap_b;
    word_t   draw_word;
    tbl_rd_t tbl_rd;
    tbl_wr_t tbl_wr;

    assign s_accept = s_tvalid && s_tready;
    assign in_draw  = (func_t'(s_tuser) == FUNC_DRAW);

    // read stage advances; seeds need no result slot
    assign s1_adv   = s1_valid_reg && (!s1_draw_reg || !out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;

    // table reads for the incoming request
    assign tbl_rd.en     = s_accept;
    assign tbl_rd.addr_a = draw_pos_reg;
    assign tbl_rd.addr_b = pos_tap(draw_pos_reg);

    // feedback word and table writeback
    assign draw_word   = tap_a ^ tap_b;
    assign tbl_wr.en   = s1_adv;
    assign tbl_wr.addr = s1_addr_reg;
    assign tbl_wr.data = s1_draw_reg ? draw_word : s1_seed_reg;

    gfsr_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd        (tbl_rd),
        .wr        (tbl_wr),
        .rd_data_a (tap_a),
        .rd_data_b (tap_b)
    );

    // draw and load positions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_pos_reg <= '0;
            load_pos_reg <= '0;
        end
        else if (s_accept)
        begin
            if (in_draw)
            begin
                draw_pos_reg <= pos_wrap_next(draw_pos_reg);
            end
            else
            begin
                draw_pos_reg <= '0;
                load_pos_reg <= pos_wrap_next(load_pos_reg);
            end
        end
    end

    // read stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_draw_reg  <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_accept;
            s1_draw_reg  <= in_draw;
        end
    end

    // read stage payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_addr_reg <= in_draw ? draw_pos_reg : load_pos_reg;
            s1_seed_reg <= independence_fix(load_pos_reg, s_tdata);
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_draw_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_draw_reg)
        begin
            out_data_reg <= draw_word;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // positions stay inside the table
    `GFSR_ASSERT_NOW(a_pos_range, 1'b1,
        (draw_pos_reg < POS_W'(TABLE_DEPTH)) && (load_pos_reg < POS_W'(TABLE_DEPTH)),
        "table position out of range")

    // a seed request rewinds the draw position
    `GFSR_ASSERT_NEXT(a_seed_rewind, s_accept && !in_draw, draw_pos_reg == '0,
        "draw position not rewound after seed")

    // a draw writes back at the position it was accepted at
    `GFSR_ASSERT_NEXT(a_draw_addr, s_accept && in_draw,
        s1_draw_reg && (s1_addr_reg == $past(draw_pos_reg)),
        "draw writeback address mismatch")

    // a draw held behind a stalled result blocks new requests
    `GFSR_ASSERT_NOW(a_stall_block,
        s1_valid_reg && s1_draw_reg && out_valid_reg && !m_tready,
        !s_tready && !tbl_wr.en,
        "request taken while draw is stalled")

endmodule
